// ===== hw/rtl/s2cd_pkg.sv =====
package s2cd_pkg;

  localparam int unsigned LineWidth = 20;
  localparam int unsigned ColW      = $clog2(LineWidth + 2);
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned CntW      = $clog2(MaxRes + 1);

  localparam logic [7:0] ByteCr       = 8'h0D;
  localparam logic [7:0] ByteLf       = 8'h0A;
  localparam logic [7:0] ByteEsc      = 8'h02;
  localparam logic [7:0] CursorBase   = 8'h30;
  localparam logic [8:0] CursorTop    = 9'(48 + 2 * LineWidth);
  localparam logic [7:0] BrightLo     = 8'h2C;
  localparam logic [7:0] BrightHi     = 8'h2F;
  localparam logic [7:0] CmdModeClear = 8'h63;
  localparam logic [7:0] CmdModeHome  = 8'h68;
  localparam logic [7:0] CmdClearNow  = 8'h78;

  localparam logic [7:0] DispClear    = 8'h01;
  localparam logic [7:0] DispHome     = 8'h02;
  localparam logic [7:0] DispBright   = 8'h33;
  localparam logic [7:0] DispSetPos   = 8'h80;
  localparam logic [7:0] DispRow2     = 8'hC0;
  localparam logic [7:0] Row2Flag     = 8'h40;

  typedef enum logic [1:0] {
    KindCmd  = 2'd0,
    KindData = 2'd1,
    KindOk   = 2'd2,
    KindNack = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
  } result_t;

  typedef struct packed {
    logic            clear_pending;
    logic            escape_pending;
    logic            clear_mode;
    logic [ColW-1:0] column;
  } state_t;

  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [CntW-1:0]      cnt;
  } batch_t;

endpackage

// ===== hw/rtl/serial_to_char_display_bridge.sv =====
// Turns received serial bytes into character-display bus writes (command or data)
// and ok/nack replies. A byte is decoded in the cycle it is accepted and its up to
// three results are loaded into a small result register. The first word is offered
// in the next cycle and the rest follow one word per cycle while the receiver takes
// them. A new byte is taken in the same cycle that the last result of the previous
// one leaves. Bytes that cause no result (CR, LF, escape) are taken whenever the
// result register is empty or its last result leaves. A stall on the result side
// holds back the next byte.
module serial_to_char_display_bridge (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] bus_value_o,
  output logic       last_o
);
  import s2cd_pkg::*;

  state_t  state_q, state_d;
  batch_t  batch;
  result_t head;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  s2cd_decode u_decode (
    .rx_byte_i (rx_byte_i),
    .state_i   (state_q),
    .state_o   (state_d),
    .batch_o   (batch)
  );

  s2cd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .batch_i     (batch),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head),
    .last_o      (last_o)
  );

  assign result_kind_o = head.kind;
  assign bus_value_o   = head.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{clear_pending: 1'b0, escape_pending: 1'b0,
                   clear_mode: 1'b1, column: '0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && out_valid_o && !out_ready_i))
    else $error("byte taken while result word stalled");

  a_column_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.column <= ColW'(LineWidth))
    else $error("column beyond line width");

  a_escape_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && rx_byte_i == ByteEsc |=> state_q.escape_pending && !out_valid_o)
    else $error("escape byte did not arm command");
`endif

endmodule

// ===== hw/rtl/s2cd_decode.sv =====
module s2cd_decode (
  input  logic [7:0]      rx_byte_i,
  input  s2cd_pkg::state_t state_i,
  output s2cd_pkg::state_t state_o,
  output s2cd_pkg::batch_t batch_o
);
  import s2cd_pkg::*;

  logic [7:0]      pos;
  logic [7:0]      bright;
  logic [ColW:0]   col_inc;
  logic [ColW-1:0] col_base;
  logic [CntW-1:0] n;

  always_comb begin
    state_o  = state_i;
    batch_o  = '0;
    n        = '0;
    pos      = rx_byte_i - CursorBase;
    bright   = rx_byte_i - BrightLo;
    col_base = state_i.column;
    col_inc  = '0;
    if (pos >= 8'(LineWidth)) begin
      pos = (pos - 8'(LineWidth)) | Row2Flag;
    end
    if (rx_byte_i == ByteCr || rx_byte_i == ByteLf) begin
      state_o.clear_pending = 1'b1;
    end else if (rx_byte_i == ByteEsc) begin
      state_o.escape_pending = 1'b1;
    end else if (state_i.escape_pending) begin
      state_o.escape_pending = 1'b0;
      if (rx_byte_i >= CursorBase && {1'b0, rx_byte_i} <= CursorTop) begin
        state_o.column    = pos[ColW-1:0];
        batch_o.res[0]    = '{kind: KindCmd, value: DispSetPos | pos};
        batch_o.res[1]    = '{kind: KindOk, value: 8'h00};
        batch_o.cnt       = CntW'(2);
      end else if (rx_byte_i >= BrightLo && rx_byte_i <= BrightHi) begin
        batch_o.res[0]    = '{kind: KindCmd, value: DispBright};
        batch_o.res[1]    = '{kind: KindData, value: {6'd0, bright[1:0]}};
        batch_o.res[2]    = '{kind: KindOk, value: 8'h00};
        batch_o.cnt       = CntW'(3);
      end else if (rx_byte_i == CmdModeClear) begin
        state_o.clear_mode = 1'b1;
        batch_o.res[0]     = '{kind: KindOk, value: 8'h00};
        batch_o.cnt        = CntW'(1);
      end else if (rx_byte_i == CmdModeHome) begin
        state_o.clear_mode = 1'b0;
        batch_o.res[0]     = '{kind: KindOk, value: 8'h00};
        batch_o.cnt        = CntW'(1);
      end else if (rx_byte_i == CmdClearNow) begin
        state_o.column = '0;
        batch_o.res[0] = '{kind: KindCmd, value: DispClear};
        batch_o.res[1] = '{kind: KindOk, value: 8'h00};
        batch_o.cnt    = CntW'(2);
      end else begin
        batch_o.res[0] = '{kind: KindNack, value: 8'h00};
        batch_o.cnt    = CntW'(1);
      end
    end else begin
      if (state_i.clear_pending) begin
        batch_o.res[0] = '{kind: KindCmd,
                           value: state_i.clear_mode ? DispClear : DispHome};
        state_o.clear_pending = 1'b0;
        col_base = '0;
        n        = CntW'(1);
      end
      batch_o.res[n] = '{kind: KindData, value: rx_byte_i};
      n       = n + CntW'(1);
      col_inc = {1'b0, col_base} + (ColW+1)'(1);
      if (col_inc > (ColW+1)'(LineWidth)) begin
        batch_o.res[n] = '{kind: KindCmd, value: DispRow2};
        n              = n + CntW'(1);
        state_o.column = '0;
      end else begin
        state_o.column = col_inc[ColW-1:0];
      end
      batch_o.cnt = n;
    end
  end

endmodule

// ===== hw/rtl/s2cd_outq.sv =====
module s2cd_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  s2cd_pkg::batch_t  batch_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output s2cd_pkg::result_t head_o,
  output logic              last_o
);
  import s2cd_pkg::*;

  result_t [MaxRes-1:0] ent_q, ent_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign last_o      = (cnt_q == CntW'(1));
  assign head_o      = ent_q[0];
  assign can_load_o  = (cnt_q == '0) || (last_o && out_ready_i);

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = batch_i.res;
      cnt_d = batch_i.cnt;
    end else if (pop) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule
